// ----- design/q4_q8_scaled_block_dot_top_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the quantized block dot product
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef Q4_Q8_SCALED_BLOCK_DOT_TOP_MACROS_SVH
`define Q4_Q8_SCALED_BLOCK_DOT_TOP_MACROS_SVH

// Same-cycle implication, disabled in reset
`define QDOT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qdot same-cycle check failed");

// Next-cycle implication, disabled in reset
`define QDOT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qdot next-cycle check failed");

`endif

// ----- design/qdot_pkg.sv -----
// ----------------------------------------------------------------------------
// qdot_pkg
// Shared types, constants and format conversions for the block dot product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qdot_pkg;

  localparam int unsigned NUM_LANES = 4;
  localparam logic [31:0] FP32_QNAN = 32'h7FC0_0000;

  // stage loads of the fp32 adder
  typedef struct packed {
    logic align;
    logic add;
    logic norm;
  } qdot_add_ctl_t;

  // fp16 bit pattern to fp32 bit pattern, exact
  function automatic logic [31:0] h2f(input logic [15:0] h);
    logic        s;
    logic [4:0]  e;
    logic [9:0]  m;
    logic [3:0]  p;
    logic [22:0] mm;
    logic [31:0] r;
    s  = h[15];
    e  = h[14:10];
    m  = h[9:0];
    p  = '0;
    mm = '0;
    for (int i = 0; i < 10; i++) begin
      if (m[i]) p = 4'(i);
    end
    if (e == 5'd0) begin
      if (m == 10'd0) begin
        r = {s, 31'd0};
      end else begin
        // fp16 subnormal is a normal fp32 value
        mm = {13'd0, m} << (5'd23 - 5'(p));
        r  = {s, 8'(p) + 8'd103, mm};
      end
    end else if (e == 5'h1F) begin
      r = {s, 8'hFF, m, 13'd0};
    end else begin
      r = {s, 8'(e) + 8'd112, m, 13'd0};
    end
    return r;
  endfunction

  // signed integer (|v| <= 32768) to fp32, exact
  function automatic logic [31:0] i2f(input logic signed [16:0] v);
    logic        s;
    logic [15:0] mag;
    logic [3:0]  p;
    logic [22:0] mm;
    logic [31:0] r;
    s   = v[16];
    mag = s ? 16'(-v) : 16'(v);
    p   = '0;
    for (int i = 0; i < 16; i++) begin
      if (mag[i]) p = 4'(i);
    end
    mm = {7'd0, mag} << (5'd23 - 5'(p));
    if (mag == 16'd0) r = 32'd0;
    else              r = {s, 8'(p) + 8'd127, mm};
    return r;
  endfunction

endpackage

// ----- design/qdot_lane.sv -----
// ----------------------------------------------------------------------------
// qdot_lane
// One lane: four x bytes against their eight y values, registered sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qdot_lane (
  input  logic               clk,
  input  logic               en,
  input  logic [31:0]        x_bytes,
  input  logic [31:0]        y_lo,
  input  logic [31:0]        y_hi,
  output logic signed [14:0] sum_r
);
  import qdot_pkg::*;

  logic signed [4:0]  lo_v [4];
  logic signed [4:0]  hi_v [4];
  logic signed [12:0] p_lo [4];
  logic signed [12:0] p_hi [4];
  logic signed [14:0] sum_nxt;

  always_comb begin
    sum_nxt = '0;
    for (int j = 0; j < 4; j++) begin
      lo_v[j] = $signed({1'b0, x_bytes[8*j +: 4]}) - 5'sd8;
      hi_v[j] = $signed({1'b0, x_bytes[8*j+4 +: 4]}) - 5'sd8;
      p_lo[j] = 13'(lo_v[j]) * 13'($signed(y_lo[8*j +: 8]));
      p_hi[j] = 13'(hi_v[j]) * 13'($signed(y_hi[8*j +: 8]));
      sum_nxt = sum_nxt + 15'(p_lo[j]) + 15'(p_hi[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) sum_r <= sum_nxt;
  end

endmodule

// ----- design/qdot_fpmul.sv -----
// ----------------------------------------------------------------------------
// qdot_fpmul
// fp32 multiply: mantissa product registered, round to nearest even after.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qdot_fpmul (
  input  logic        clk,
  input  logic        ld,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] y
);
  import qdot_pkg::*;

  // operands here are zero, normal, inf or NaN; finite products stay in the
  // normal range (scales >= 2^-48, integer sums <= 2^15), so no under/overflow
  logic        a_zero, b_zero, a_inf, b_inf, a_nan, b_nan;
  logic        nan_r, inf_r, zero_r, sign_r;
  logic [8:0]  esum_r;
  logic [47:0] prod_r;

  logic [9:0]  e10;
  logic [22:0] m;
  logic        g, st, inc;
  logic [24:0] m25;

  always_comb begin
    a_zero = (a[30:23] == 8'd0);
    b_zero = (b[30:23] == 8'd0);
    a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      nan_r  <= a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero);
      inf_r  <= a_inf || b_inf;
      zero_r <= a_zero || b_zero;
      sign_r <= a[31] ^ b[31];
      esum_r <= {1'b0, a[30:23]} + {1'b0, b[30:23]};
      prod_r <= {24'd0, 1'b1, a[22:0]} * {24'd0, 1'b1, b[22:0]};
    end
  end

  always_comb begin
    e10 = {1'b0, esum_r} - 10'd127;
    if (prod_r[47]) begin
      m   = prod_r[46:24];
      g   = prod_r[23];
      st  = |prod_r[22:0];
      e10 = e10 + 10'd1;
    end else begin
      m   = prod_r[45:23];
      g   = prod_r[22];
      st  = |prod_r[21:0];
    end
    inc = g && (st || m[0]);
    m25 = {2'b01, m} + 25'(inc);
    if (m25[24]) e10 = e10 + 10'd1;
    if (nan_r)       y = FP32_QNAN;
    else if (inf_r)  y = {sign_r, 8'hFF, 23'd0};
    else if (zero_r) y = {sign_r, 31'd0};
    else if (m25[24]) y = {sign_r, e10[7:0], 23'd0};
    else             y = {sign_r, e10[7:0], m25[22:0]};
  end

endmodule

// ----- design/qdot_fpadd.sv -----
// ----------------------------------------------------------------------------
// qdot_fpadd
// fp32 add in three registered steps (align, add, leading-zero count) and a
// final normalize and round to nearest even.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qdot_fpadd (
  input  logic                   clk,
  input  qdot_pkg::qdot_add_ctl_t ctl,
  input  logic [31:0]            a,
  input  logic [31:0]            b,
  output logic [31:0]            y
);
  import qdot_pkg::*;

  // all finite values seen are multiples of 2^-48, so results never go
  // subnormal; overflow to infinity is handled
  logic        a_inf, b_inf, a_nan, b_nan, a_big;
  logic [7:0]  ea, eb, e_big, e_sml, d;
  logic [23:0] ma, mb, m_big, m_sml;
  logic [26:0] ext, sh, msk;
  logic [26:0] aligned;

  logic        s1_nan, s1_inf, s1_isign, s1_zsign, s1_sub, s1_sign;
  logic [7:0]  s1_exp;
  logic [23:0] s1_mb;
  logic [26:0] s1_ms;

  logic        s2_nan, s2_inf, s2_isign, s2_zsign, s2_sign;
  logic [7:0]  s2_exp;
  logic [27:0] s2_sum;

  logic        s3_nan, s3_inf, s3_isign, s3_zsign, s3_sign;
  logic [7:0]  s3_exp;
  logic [27:0] s3_sum;
  logic [4:0]  s3_lz;

  logic [4:0]  lz;
  logic [26:0] n27;
  logic [9:0]  e10;
  logic        g, st, inc;
  logic [24:0] m25;

  // align
  always_comb begin
    ea    = a[30:23];
    eb    = b[30:23];
    ma    = (ea == 8'd0) ? 24'd0 : {1'b1, a[22:0]};
    mb    = (eb == 8'd0) ? 24'd0 : {1'b1, b[22:0]};
    a_inf = (ea == 8'hFF) && (a[22:0] == 23'd0);
    b_inf = (eb == 8'hFF) && (b[22:0] == 23'd0);
    a_nan = (ea == 8'hFF) && (a[22:0] != 23'd0);
    b_nan = (eb == 8'hFF) && (b[22:0] != 23'd0);
    a_big = (a[30:0] >= b[30:0]);
    e_big = a_big ? ea : eb;
    e_sml = a_big ? eb : ea;
    m_big = a_big ? ma : mb;
    m_sml = a_big ? mb : ma;
    d     = e_big - e_sml;
    ext   = {m_sml, 3'd0};
    sh    = ext >> d[4:0];
    msk   = ~({27{1'b1}} << d[4:0]);
    if (d >= 8'd27) aligned = {26'd0, |ext};
    else            aligned = sh | {26'd0, |(ext & msk)};
  end

  always_ff @(posedge clk) begin
    if (ctl.align) begin
      s1_nan   <= a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]));
      s1_inf   <= a_inf || b_inf;
      s1_isign <= a_inf ? a[31] : b[31];
      s1_zsign <= a[31] && b[31];
      s1_sub   <= a[31] ^ b[31];
      s1_sign  <= a_big ? a[31] : b[31];
      s1_exp   <= e_big;
      s1_mb    <= m_big;
      s1_ms    <= aligned;
    end
  end

  // add
  always_ff @(posedge clk) begin
    if (ctl.add) begin
      s2_nan   <= s1_nan;
      s2_inf   <= s1_inf;
      s2_isign <= s1_isign;
      s2_zsign <= s1_zsign;
      s2_sign  <= s1_sign;
      s2_exp   <= s1_exp;
      if (s1_sub) s2_sum <= {1'b0, s1_mb, 3'd0} - {1'b0, s1_ms};
      else        s2_sum <= {1'b0, s1_mb, 3'd0} + {1'b0, s1_ms};
    end
  end

  // leading-zero count below the carry bit
  always_comb begin
    lz = '0;
    for (int i = 0; i < 27; i++) begin
      if (s2_sum[i]) lz = 5'(26 - i);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.norm) begin
      s3_nan   <= s2_nan;
      s3_inf   <= s2_inf;
      s3_isign <= s2_isign;
      s3_zsign <= s2_zsign;
      s3_sign  <= s2_sign;
      s3_exp   <= s2_exp;
      s3_sum   <= s2_sum;
      s3_lz    <= lz;
    end
  end

  // normalize and round
  always_comb begin
    if (s3_sum[27]) begin
      n27 = {s3_sum[27:2], |s3_sum[1:0]};
      e10 = {2'd0, s3_exp} + 10'd1;
    end else begin
      n27 = s3_sum[26:0] << s3_lz;
      e10 = {2'd0, s3_exp} - {5'd0, s3_lz};
    end
    g   = n27[2];
    st  = |n27[1:0];
    inc = g && (st || n27[3]);
    m25 = {1'b0, n27[26:3]} + 25'(inc);
    if (m25[24]) e10 = e10 + 10'd1;
    if (s3_nan)                   y = FP32_QNAN;
    else if (s3_inf)              y = {s3_isign, 8'hFF, 23'd0};
    else if (s3_sum == 28'd0)     y = {s3_zsign, 31'd0};
    else if (e10 >= 10'd255)      y = {s3_sign, 8'hFF, 23'd0};
    else if (m25[24])             y = {s3_sign, e10[7:0], 23'd0};
    else                          y = {s3_sign, e10[7:0], m25[22:0]};
  end

endmodule

// ----- design/q4_q8_scaled_block_dot_top.sv -----
// ----------------------------------------------------------------------------
// q4_q8_scaled_block_dot_top
// Scaled dot product of 4-bit and 8-bit quantized block pairs, fp32 total.
// ----------------------------------------------------------------------------
// Each item is one block pair; an item with last_block set produces one
// result, the fp32 total over all blocks since the previous last block, and
// then restarts the total at +0 (NaN totals come out as 0x7FC00000). One item
// is worked at a time, and the next item is taken in the idle state or in the
// final rounding step of the current one: four lanes form the integer sum,
// then the single shared fp32 multiplier (scale product, then sum times scale)
// and the three-step fp32 adder on the accumulator run in series. A finished result
// waits in the output register while the next item is taken; only a second
// last block finding that register still full holds the block.
`timescale 1ns / 1ps

module q4_q8_scaled_block_dot_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_x_scale,
  input  logic [63:0] in_x_nibbles_lo,
  input  logic [63:0] in_x_nibbles_hi,
  input  logic [15:0] in_y_scale,
  input  logic [63:0] in_y_bytes_0,
  input  logic [63:0] in_y_bytes_1,
  input  logic [63:0] in_y_bytes_2,
  input  logic [63:0] in_y_bytes_3,
  input  logic        in_last_block,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_dot_total
);
  import qdot_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE, PH_LANE, PH_MERGE, PH_CONV, PH_MUL,
    PH_TERM, PH_ALIGN, PH_ADD, PH_LZC, PH_ROUND
  } phase_t;

  phase_t ph_r, ph_nxt;
  logic   accept, blk;

  logic [15:0]  xs_r, ys_r;
  logic [127:0] x_r;
  logic [255:0] y_r;
  logic         last_r;

  logic signed [14:0] lane_sum [NUM_LANES];
  logic signed [16:0] sumi_r;
  logic [31:0]        sumf_r, scale_r, term_r, acc_r, acc_nxt;
  logic [31:0]        mul_a, mul_b, mul_y, add_y;
  logic               mul_ld;
  qdot_add_ctl_t      add_ctl;
  logic               out_valid_r, out_valid_nxt;
  logic [31:0]        out_data_r, out_data_nxt;

  // a last block cannot finish while the previous total is still held
  assign blk      = last_r && out_valid_r && out_stall;
  assign in_stall = !((ph_r == PH_IDLE) || ((ph_r == PH_ROUND) && !blk));
  assign accept   = in_valid && !in_stall;

  generate
    for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
      qdot_lane u_lane (
        .clk     (clk),
        .en      (ph_r == PH_LANE),
        .x_bytes (x_r[32*k +: 32]),
        .y_lo    (y_r[32*k +: 32]),
        .y_hi    (y_r[128 + 32*k +: 32]),
        .sum_r   (lane_sum[k])
      );
    end
  endgenerate

  assign mul_ld = (ph_r == PH_LANE) || (ph_r == PH_MUL);
  assign mul_a  = (ph_r == PH_LANE) ? h2f(xs_r) : sumf_r;
  assign mul_b  = (ph_r == PH_LANE) ? h2f(ys_r) : scale_r;

  qdot_fpmul u_mul (
    .clk (clk),
    .ld  (mul_ld),
    .a   (mul_a),
    .b   (mul_b),
    .y   (mul_y)
  );

  assign add_ctl.align = (ph_r == PH_ALIGN);
  assign add_ctl.add   = (ph_r == PH_ADD);
  assign add_ctl.norm  = (ph_r == PH_LZC);

  qdot_fpadd u_add (
    .clk (clk),
    .ctl (add_ctl),
    .a   (acc_r),
    .b   (term_r),
    .y   (add_y)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      xs_r   <= in_x_scale;
      ys_r   <= in_y_scale;
      x_r    <= {in_x_nibbles_hi, in_x_nibbles_lo};
      y_r    <= {in_y_bytes_3, in_y_bytes_2, in_y_bytes_1, in_y_bytes_0};
      last_r <= in_last_block;
    end
    if (ph_r == PH_MERGE) begin
      sumi_r  <= 17'(lane_sum[0]) + 17'(lane_sum[1]) + 17'(lane_sum[2])
               + 17'(lane_sum[3]);
      scale_r <= mul_y;
    end
    if (ph_r == PH_CONV) sumf_r <= i2f(sumi_r);
    if (ph_r == PH_TERM) term_r <= mul_y;
  end

  always_comb begin
    ph_nxt        = ph_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    unique case (ph_r)
      PH_IDLE:  if (accept) ph_nxt = PH_LANE;
      PH_LANE:  ph_nxt = PH_MERGE;
      PH_MERGE: ph_nxt = PH_CONV;
      PH_CONV:  ph_nxt = PH_MUL;
      PH_MUL:   ph_nxt = PH_TERM;
      PH_TERM:  ph_nxt = PH_ALIGN;
      PH_ALIGN: ph_nxt = PH_ADD;
      PH_ADD:   ph_nxt = PH_LZC;
      PH_LZC:   ph_nxt = PH_ROUND;
      PH_ROUND: begin
        if (!blk) begin
          ph_nxt = accept ? PH_LANE : PH_IDLE;
          if (last_r) begin
            acc_nxt       = 32'd0;
            out_valid_nxt = 1'b1;
            out_data_nxt  = ((add_y[30:23] == 8'hFF) && (add_y[22:0] != 23'd0))
                          ? FP32_QNAN : add_y;
          end else begin
            acc_nxt = add_y;
          end
        end
      end
      default:  ph_nxt = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r        <= PH_IDLE;
      acc_r       <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      ph_r        <= ph_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_dot_total = out_data_r;

endmodule

// ----- design/qdot_chk.sv -----
// ----------------------------------------------------------------------------
// qdot_chk
// Port-level checks on the block dot product, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "q4_q8_scaled_block_dot_top_macros.svh"

module qdot_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_dot_total
);
  import qdot_pkg::*;

  logic out_wait;
  logic out_is_nan;

  assign out_wait   = out_valid && out_stall;
  assign out_is_nan = (out_dot_total[30:23] == 8'hFF) && (out_dot_total[22:0] != 23'd0);

  // a waiting result holds
  `QDOT_ASSERT_NXT(a_out_hold, clk, rst_n, out_wait, out_valid && $stable(out_dot_total))

  // one item at a time: the cycle after an accept takes nothing
  `QDOT_ASSERT_NXT(a_one_item, clk, rst_n, in_valid && !in_stall, in_stall)

  // NaN totals leave in canonical form
  `QDOT_ASSERT_IMP(a_qnan, clk, rst_n, out_valid && out_is_nan, out_dot_total == FP32_QNAN)

endmodule

bind q4_q8_scaled_block_dot_top qdot_chk u_qdot_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_dot_total (out_dot_total)
);
